### src/range_bar_ohlc_aggregator_assert.svh
// Assertion macros shared by the range bar checker.
`ifndef RANGE_BAR_OHLC_AGGREGATOR_ASSERT_SVH
`define RANGE_BAR_OHLC_AGGREGATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RBO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range bar check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RBO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range bar check failed");

`endif

### src/rbo_pkg.sv
// Shared constants and types for the range bar OHLC aggregator.
`timescale 1ns / 1ps

package rbo_pkg;

    localparam int PRICE_BITS_DEF = 48;
    localparam int RANGE_BITS     = 48;
    localparam int SIZE_BITS      = 48;
    localparam int TIME_BITS      = 63;
    localparam int VOL_BITS       = 63;

    localparam logic [RANGE_BITS-1:0] RANGE_RESET = RANGE_BITS'(100);

    // Status of one processed trade, core to output stage.
    typedef struct packed {
        logic emit;   // a bar completed and had been opened
        logic gap;    // close level set by a gap jump
    } result_ctl_t;

endpackage

### src/rbo_in_stage.sv
// Input register for one trade word.
`timescale 1ns / 1ps

module rbo_in_stage #(
    parameter int PRICE_BITS = rbo_pkg::PRICE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [PRICE_BITS-1:0]          price,
    input  logic [rbo_pkg::SIZE_BITS-1:0]  size,
    input  logic [rbo_pkg::TIME_BITS-1:0]  trade_time,
    input  logic                           advance,
    output logic                           held_valid,
    output logic [PRICE_BITS-1:0]          held_price,
    output logic [rbo_pkg::SIZE_BITS-1:0]  held_size,
    output logic [rbo_pkg::TIME_BITS-1:0]  held_time
);
    import rbo_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [PRICE_BITS-1:0] price_reg;
    logic [SIZE_BITS-1:0]  size_reg;
    logic [TIME_BITS-1:0]  time_reg;
    logic                  take;

    // Full register that cannot drain this cycle blocks the sender.
    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            price_reg <= price;
            size_reg  <= size;
            time_reg  <= trade_time;
        end
    end

    assign held_valid = valid_reg;
    assign held_price = price_reg;
    assign held_size  = size_reg;
    assign held_time  = time_reg;

endmodule

### src/rbo_bar_core.sv
// Bar state registers and the per-trade range bar update.
`timescale 1ns / 1ps

module rbo_bar_core #(
    parameter int PRICE_BITS = rbo_pkg::PRICE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [rbo_pkg::RANGE_BITS-1:0] bar_range,
    input  logic                           advance,
    input  logic [PRICE_BITS-1:0]          price,
    input  logic [rbo_pkg::SIZE_BITS-1:0]  size,
    input  logic [rbo_pkg::TIME_BITS-1:0]  trade_time,
    output rbo_pkg::result_ctl_t           ctl,
    output logic [PRICE_BITS-1:0]          res_open,
    output logic [PRICE_BITS-1:0]          res_high,
    output logic [PRICE_BITS-1:0]          res_low,
    output logic [PRICE_BITS-1:0]          res_close,
    output logic [rbo_pkg::VOL_BITS-1:0]   res_volume,
    output logic [rbo_pkg::TIME_BITS-1:0]  res_open_time,
    output logic [rbo_pkg::TIME_BITS-1:0]  res_close_time
);
    import rbo_pkg::*;

    // Working width: room for 2*range and for either operand.
    localparam int CW = ((PRICE_BITS > RANGE_BITS) ? PRICE_BITS : RANGE_BITS) + 2;

    logic [PRICE_BITS-1:0] open_reg,  open_next;
    logic [PRICE_BITS-1:0] high_reg,  high_next;
    logic [PRICE_BITS-1:0] low_reg,   low_next;
    logic [VOL_BITS-1:0]   vol_reg,   vol_next;
    logic [TIME_BITS-1:0]  otime_reg, otime_next;

    logic [CW-1:0]         p_x, lo_x, hi_x, r_x;
    logic [CW-1:0]         up_diff, dn_diff;
    logic                  up_close, dn_close, up_gap, dn_gap;
    logic [PRICE_BITS-1:0] up_level, dn_level;
    logic [VOL_BITS:0]     vol_sum;
    logic [VOL_BITS-1:0]   vol_add;

    assign p_x  = CW'(price);
    assign lo_x = CW'(low_reg);
    assign hi_x = CW'(high_reg);
    assign r_x  = CW'(bar_range);

    assign up_diff  = p_x - lo_x;
    assign dn_diff  = hi_x - p_x;
    assign up_close = (price > low_reg) && (up_diff > r_x);
    assign dn_close = (high_reg > price) && (dn_diff > r_x);
    // jump beyond two ranges
    assign up_gap   = up_diff > (r_x << 1);
    assign dn_gap   = dn_diff > (r_x << 1);

    // Levels stay inside [low, high] of this trade, so they fit the price width.
    assign up_level = up_gap ? PRICE_BITS'(p_x - r_x) : PRICE_BITS'(lo_x + r_x);
    assign dn_level = dn_gap ? PRICE_BITS'(p_x + r_x) : PRICE_BITS'(hi_x - r_x);

    assign vol_sum = {1'b0, vol_reg} + (VOL_BITS + 1)'(size);
    assign vol_add = vol_sum[VOL_BITS] ? {VOL_BITS{1'b1}} : vol_sum[VOL_BITS-1:0];

    always_comb
    begin
        res_open       = open_reg;
        res_high       = high_reg;
        res_low        = low_reg;
        res_close      = price;
        res_volume     = vol_reg;
        res_open_time  = otime_reg;
        res_close_time = trade_time;
        ctl.emit       = 1'b0;
        ctl.gap        = 1'b0;

        open_next  = open_reg;
        high_next  = (price > high_reg) ? price : high_reg;
        low_next   = (price < low_reg) ? price : low_reg;
        vol_next   = vol_add;
        otime_next = otime_reg;

        if (up_close)
        begin
            res_high   = (up_level > high_reg) ? up_level : high_reg;
            res_close  = up_level;
            ctl.gap    = up_gap;
            ctl.emit   = (otime_reg != '0);
            open_next  = up_level;
            high_next  = price;
            low_next   = up_level;
            vol_next   = VOL_BITS'(size);
            otime_next = trade_time;
        end
        else if (dn_close)
        begin
            res_low    = (dn_level < low_reg) ? dn_level : low_reg;
            res_close  = dn_level;
            ctl.gap    = dn_gap;
            ctl.emit   = (otime_reg != '0);
            open_next  = dn_level;
            high_next  = dn_level;
            low_next   = price;
            vol_next   = VOL_BITS'(size);
            otime_next = trade_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= '0;
            high_reg  <= '0;
            low_reg   <= '0;
            vol_reg   <= '0;
            otime_reg <= '0;
        end
        else if (advance)
        begin
            open_reg  <= open_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            vol_reg   <= vol_next;
            otime_reg <= otime_next;
        end
    end

endmodule

### src/rbo_out_stage.sv
// Output register holding one completed bar word.
`timescale 1ns / 1ps

module rbo_out_stage #(
    parameter int PRICE_BITS = rbo_pkg::PRICE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  rbo_pkg::result_ctl_t           ctl,
    input  logic [PRICE_BITS-1:0]          res_open,
    input  logic [PRICE_BITS-1:0]          res_high,
    input  logic [PRICE_BITS-1:0]          res_low,
    input  logic [PRICE_BITS-1:0]          res_close,
    input  logic [rbo_pkg::VOL_BITS-1:0]   res_volume,
    input  logic [rbo_pkg::TIME_BITS-1:0]  res_open_time,
    input  logic [rbo_pkg::TIME_BITS-1:0]  res_close_time,
    output logic                           slot_free,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [PRICE_BITS-1:0]          open_price,
    output logic [PRICE_BITS-1:0]          high_price,
    output logic [PRICE_BITS-1:0]          low_price,
    output logic [PRICE_BITS-1:0]          close_price,
    output logic [rbo_pkg::VOL_BITS-1:0]   bar_volume,
    output logic [rbo_pkg::TIME_BITS-1:0]  open_time,
    output logic [rbo_pkg::TIME_BITS-1:0]  close_time,
    output logic                           gap_seen
);
    import rbo_pkg::*;

    logic                  valid_reg, valid_next;
    logic                  load;
    logic [PRICE_BITS-1:0] open_reg, high_reg, low_reg, close_reg;
    logic [VOL_BITS-1:0]   vol_reg;
    logic [TIME_BITS-1:0]  otime_reg, ctime_reg;
    logic                  gap_reg;

    assign slot_free = !valid_reg || !out_stall;
    assign load      = advance && ctl.emit;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            open_reg  <= res_open;
            high_reg  <= res_high;
            low_reg   <= res_low;
            close_reg <= res_close;
            vol_reg   <= res_volume;
            otime_reg <= res_open_time;
            ctime_reg <= res_close_time;
            gap_reg   <= ctl.gap;
        end
    end

    assign out_valid   = valid_reg;
    assign open_price  = open_reg;
    assign high_price  = high_reg;
    assign low_price   = low_reg;
    assign close_price = close_reg;
    assign bar_volume  = vol_reg;
    assign open_time   = otime_reg;
    assign close_time  = ctime_reg;
    assign gap_seen    = gap_reg;

endmodule

### src/range_bar_ohlc_aggregator.sv
// Top level of the range bar OHLC aggregator.
//
//  channel  | direction | handshake           | word
//  ---------+-----------+---------------------+-----------------------------------------
//  trade    | in        | in_valid / in_stall | price, size, trade_time
//  bar      | out       | out_valid/out_stall | open/high/low/close_price, bar_volume,
//           |           |                     | open_time, close_time, gap_seen
//  config   | in        | bar_range_we        | bar_range_wdata (48-bit range in ticks)
//
// One trade word per cycle sustained while no bar word is stalled. A trade waits in the
// input register, where the bar update runs against the state registers; a completed
// bar is loaded into the output register as the trade advances, then shows on out_valid.
// Reset clears the bar state (no bar opened), both valid flags, and sets range to 100.
// A bar word held under out_stall keeps the input register from draining; while a trade
// is held there and out_valid is high, in_stall follows out_stall in the same cycle.
// Trades closing no bar wait too. Write bar_range only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps

module range_bar_ohlc_aggregator #(
    parameter int PRICE_BITS = rbo_pkg::PRICE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           bar_range_we,
    input  logic [rbo_pkg::RANGE_BITS-1:0] bar_range_wdata,
    // trade input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [PRICE_BITS-1:0]          price,
    input  logic [rbo_pkg::SIZE_BITS-1:0]  size,
    input  logic [rbo_pkg::TIME_BITS-1:0]  trade_time,
    // completed bar output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [PRICE_BITS-1:0]          open_price,
    output logic [PRICE_BITS-1:0]          high_price,
    output logic [PRICE_BITS-1:0]          low_price,
    output logic [PRICE_BITS-1:0]          close_price,
    output logic [rbo_pkg::VOL_BITS-1:0]   bar_volume,
    output logic [rbo_pkg::TIME_BITS-1:0]  open_time,
    output logic [rbo_pkg::TIME_BITS-1:0]  close_time,
    output logic                           gap_seen
);
    import rbo_pkg::*;

    logic [RANGE_BITS-1:0] range_reg;

    logic                  held_valid;
    logic [PRICE_BITS-1:0] held_price;
    logic [SIZE_BITS-1:0]  held_size;
    logic [TIME_BITS-1:0]  held_time;

    logic                  slot_free;
    logic                  advance;
    result_ctl_t           ctl;

    logic [PRICE_BITS-1:0] res_open, res_high, res_low, res_close;
    logic [VOL_BITS-1:0]   res_volume;
    logic [TIME_BITS-1:0]  res_open_time, res_close_time;

    // Range register; no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= RANGE_RESET;
        end
        else if (bar_range_we)
        begin
            range_reg <= bar_range_wdata;
        end
    end

    // A held trade is processed only when the output slot can take a bar,
    // whether or not this trade closes one.
    assign advance = held_valid && slot_free;

    rbo_in_stage #(
        .PRICE_BITS (PRICE_BITS)
    ) u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .price      (price),
        .size       (size),
        .trade_time (trade_time),
        .advance    (advance),
        .held_valid (held_valid),
        .held_price (held_price),
        .held_size  (held_size),
        .held_time  (held_time)
    );

    rbo_bar_core #(
        .PRICE_BITS (PRICE_BITS)
    ) u_bar_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .bar_range      (range_reg),
        .advance        (advance),
        .price          (held_price),
        .size           (held_size),
        .trade_time     (held_time),
        .ctl            (ctl),
        .res_open       (res_open),
        .res_high       (res_high),
        .res_low        (res_low),
        .res_close      (res_close),
        .res_volume     (res_volume),
        .res_open_time  (res_open_time),
        .res_close_time (res_close_time)
    );

    rbo_out_stage #(
        .PRICE_BITS (PRICE_BITS)
    ) u_out_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .ctl            (ctl),
        .res_open       (res_open),
        .res_high       (res_high),
        .res_low        (res_low),
        .res_close      (res_close),
        .res_volume     (res_volume),
        .res_open_time  (res_open_time),
        .res_close_time (res_close_time),
        .slot_free      (slot_free),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .open_price     (open_price),
        .high_price     (high_price),
        .low_price      (low_price),
        .close_price    (close_price),
        .bar_volume     (bar_volume),
        .open_time      (open_time),
        .close_time     (close_time),
        .gap_seen       (gap_seen)
    );

endmodule

### src/rbo_checker.sv
// Port-level checker for the range bar aggregator, bound to the top level.
`timescale 1ns / 1ps
`include "range_bar_ohlc_aggregator_assert.svh"

module rbo_checker #(
    parameter int PRICE_BITS = rbo_pkg::PRICE_BITS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           bar_range_we,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [PRICE_BITS-1:0]          price,
    input logic [rbo_pkg::SIZE_BITS-1:0]  size,
    input logic [rbo_pkg::TIME_BITS-1:0]  trade_time,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [PRICE_BITS-1:0]          open_price,
    input logic [PRICE_BITS-1:0]          high_price,
    input logic [PRICE_BITS-1:0]          low_price,
    input logic [PRICE_BITS-1:0]          close_price,
    input logic [rbo_pkg::VOL_BITS-1:0]   bar_volume,
    input logic [rbo_pkg::TIME_BITS-1:0]  open_time,
    input logic [rbo_pkg::TIME_BITS-1:0]  close_time,
    input logic                           gap_seen
);
    import rbo_pkg::*;

    localparam int IN_W  = PRICE_BITS + SIZE_BITS + TIME_BITS;
    localparam int OUT_W = 4 * PRICE_BITS + VOL_BITS + 2 * TIME_BITS + 1;

    logic [IN_W-1:0]  in_word;
    logic [OUT_W-1:0] out_word;
    logic             ohlc_ok;

    assign in_word  = {price, size, trade_time};
    assign out_word = {open_price, high_price, low_price, close_price,
                       bar_volume, open_time, close_time, gap_seen};
    assign ohlc_ok  = (low_price <= open_price) && (open_price <= high_price) &&
                      (low_price <= close_price) && (close_price <= high_price);

    // stalled bar word stays and holds its payload
    `RBO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

    // stalled trade word stays and holds its payload
    `RBO_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_word))

    // only bars that were really opened leave the block
    `RBO_ASSERT_NOW(a_opened, out_valid, open_time != '0)

    // open and close lie inside the bar's low..high span
    `RBO_ASSERT_NOW(a_ohlc_order, out_valid, ohlc_ok)

    // range is written only while no word is on either channel
    `RBO_ASSERT_NOW(a_cfg_idle, bar_range_we, !in_valid && !out_valid)

endmodule

bind range_bar_ohlc_aggregator rbo_checker #(.PRICE_BITS(PRICE_BITS)) u_rbo_checker (.*);
